>>> src/kbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_pkg
// shared types and constants of the k-mer bloom filter insert block
// ----------------------------------------------------------------------------
package kbf_pkg;

    localparam int CHAR_W  = 8;
    localparam int HASH_W  = 32;
    localparam int FBITS_W = 17;
    localparam int HCNT_W  = 4;
    localparam int CNT_W   = 32;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 32;

    localparam logic [CIDX_W-1:0] REG_FILTER_BITS = 1'd0;
    localparam logic [CIDX_W-1:0] REG_HASH_COUNT  = 1'd1;

    localparam logic [FBITS_W-1:0] FILTER_BITS_RST = 17'd47925;
    localparam logic [HCNT_W-1:0]  HASH_COUNT_RST  = 4'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_SET,
        ST_OUT
    } kbf_state_t;

endpackage

>>> src/kbf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_if
// valid/ready channel interfaces for input, output and configuration words
// ----------------------------------------------------------------------------
interface kbf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       read_start;
    modport source (output valid, base_char, read_start, input ready);
    modport sink   (input valid, base_char, read_start, output ready);
endinterface

interface kbf_out_if;
    logic        valid;
    logic        ready;
    logic        is_new;
    logic [31:0] distinct_count;
    modport source (output valid, is_new, distinct_count, input ready);
    modport sink   (input valid, is_new, distinct_count, output ready);
endinterface

interface kbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/kmer_bloom_filter_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bloom_filter_insert
// sliding k-mer window, polynomial hashes, bloom filter test and insert
// ----------------------------------------------------------------------------
// steps: while the window fills a word only shifts in; else per hash the window
//   runs on the shared 32x32 multiplier, then a bit-serial modulo; then a check
//   read per hash, a read-and-write-back set per hash when new, and the result
// throughput: one word at a time; the next word is taken while a result waits
// reset: a clearing pass sweeps the filter memory row by row, and
//   configuration writes are taken meanwhile
module kmer_bloom_filter_insert
    import kbf_pkg::*;
#(
    parameter int KMER_LEN   = 40,
    parameter int MAX_HASHES = 8,
    parameter int STORE_BITS = 65536
)(
    input  logic       clk,
    input  logic       rst_n,
    kbf_in_if.sink     in_ch,
    kbf_out_if.source  out_ch,
    kbf_cfg_if.sink    cfg
);
    localparam int ROWS   = (STORE_BITS + 31) / 32;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = $clog2(STORE_BITS);
    localparam int POS_W  = $clog2(KMER_LEN + 1);
    localparam int HI_W   = $clog2(MAX_HASHES + 1);
    localparam int HS_W   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int WIN_W  = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;

    kbf_state_t state_reg, state_next;

    logic [FBITS_W-1:0] fbits_reg;
    logic [HCNT_W-1:0]  hcnt_reg;
    logic [CHAR_W-1:0]  win_reg [KMER_LEN];
    logic [POS_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [31:0]        mem [ROWS];
    logic [31:0]        rdata_reg;
    logic [ROW_W-1:0]   clr_reg;
    logic [HASH_W-1:0]  acc_reg, pw_reg, base_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               phase_reg;
    logic [HI_W-1:0]    hidx_reg, nh_reg;
    logic [IDX_W:0]     mod_reg;
    logic [IDX_W:0]     rem_reg;
    logic [5:0]         bit_reg;
    logic [IDX_W-1:0]   scratch [MAX_HASHES];
    logic               fresh_reg;
    logic               ovalid_reg, onew_reg;

    // effective modulus and hash count
    logic [IDX_W:0]  mod_eff;
    logic [HI_W-1:0] nh_eff;
    always_comb
    begin
        if (fbits_reg == '0)
            mod_eff = (IDX_W+1)'(1);
        else if (32'(fbits_reg) > 32'(STORE_BITS))
            mod_eff = (IDX_W+1)'(STORE_BITS);
        else
            mod_eff = (IDX_W+1)'(fbits_reg);
        if (hcnt_reg == '0)
            nh_eff = HI_W'(1);
        else if (32'(hcnt_reg) > 32'(MAX_HASHES))
            nh_eff = HI_W'(MAX_HASHES);
        else
            nh_eff = HI_W'(hcnt_reg);
    end

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.is_new = onew_reg;
    assign out_ch.distinct_count = total_reg;

    logic [POS_W-1:0] fill_inc;
    assign fill_inc = (in_ch.read_start ? '0 : fill_reg) + POS_W'(1);

    // shared multiplier: pw*base or char*pw
    logic [HASH_W-1:0] mul_a, mul_b, mul_p;
    always_comb
    begin
        mul_a = pw_reg;
        mul_b = phase_reg ? HASH_W'(win_reg[pos_reg[WIN_W-1:0]]) : base_reg;
    end
    assign mul_p = mul_a * mul_b;

    // restoring modulo step: remainder doubles in one hash bit
    logic [IDX_W+1:0] rem_sh;
    assign rem_sh = {rem_reg, acc_reg[5'(bit_reg)]};

    logic [IDX_W-1:0] cur_idx;
    assign cur_idx = scratch[hidx_reg[HS_W-1:0]];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (32'(clr_reg) == ROWS - 1) state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire && 32'(fill_inc) >= KMER_LEN)
                    state_next = ST_MAC;
            ST_MAC:
                if (phase_reg && 32'(pos_reg) == KMER_LEN - 1) state_next = ST_MOD;
            ST_MOD:
                if (bit_reg == 6'd0)
                    state_next = (hidx_reg == nh_reg - HI_W'(1)) ? ST_RD : ST_MAC;
            ST_RD:  state_next = ST_CHK;
            ST_CHK:
                if (hidx_reg == nh_reg - HI_W'(1))
                    state_next = ST_SET;
                else
                    state_next = ST_RD;
            // set pass, only for a new k-mer: read the row, then write it back with the bit
            ST_SET:
                if (!fresh_reg || (phase_reg && hidx_reg == nh_reg - HI_W'(1)))
                    state_next = ST_OUT;
            // wait here while the previous result word is still pending
            ST_OUT: if (!ovalid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            fbits_reg  <= FILTER_BITS_RST;
            hcnt_reg   <= HASH_COUNT_RST;
            fill_reg   <= '0;
            total_reg  <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
            hidx_reg   <= '0;
            fresh_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_FILTER_BITS: fbits_reg <= cfg.data[FBITS_W-1:0];
                    REG_HASH_COUNT:  hcnt_reg  <= cfg.data[HCNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + ROW_W'(1);
                ST_IDLE:
                    if (in_fire)
                    begin
                        fill_reg  <= (32'(fill_inc) > KMER_LEN) ? POS_W'(KMER_LEN) : fill_inc;
                        phase_reg <= 1'b0;
                        hidx_reg  <= '0;
                        fresh_reg <= 1'b0;
                    end
                ST_MAC:
                    begin
                        phase_reg <= ~phase_reg;
                        if (phase_reg && 32'(pos_reg) == KMER_LEN - 1)
                            phase_reg <= 1'b0;
                    end
                ST_MOD:
                    if (bit_reg == 6'd0)
                    begin
                        if (hidx_reg == nh_reg - HI_W'(1))
                            hidx_reg <= '0;
                        else
                            hidx_reg <= hidx_reg + HI_W'(1);
                    end
                ST_CHK:
                    begin
                        if (!rdata_reg[cur_idx[4:0]])
                            fresh_reg <= 1'b1;
                        if (hidx_reg == nh_reg - HI_W'(1))
                            hidx_reg <= '0;
                        else
                            hidx_reg <= hidx_reg + HI_W'(1);
                    end
                ST_SET:
                    if (fresh_reg)
                    begin
                        phase_reg <= ~phase_reg;
                        if (phase_reg)
                            hidx_reg <= hidx_reg + HI_W'(1);
                    end
                ST_OUT:
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        if (fresh_reg && total_reg != '1)
                            total_reg <= total_reg + CNT_W'(1);
                    end
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    for (int k = 0; k < KMER_LEN - 1; k++)
                        win_reg[k] <= in_ch.read_start ? '0 : win_reg[k+1];
                    win_reg[KMER_LEN-1] <= in_ch.base_char;
                    mod_reg  <= mod_eff;
                    nh_reg   <= nh_eff;
                    acc_reg  <= '0;
                    pw_reg   <= HASH_W'(1);
                    base_reg <= HASH_W'(1);
                    pos_reg  <= '0;
                end
            ST_MAC:
                if (!phase_reg)
                    pw_reg <= mul_p;
                else
                begin
                    acc_reg <= acc_reg + mul_p;
                    pos_reg <= pos_reg + POS_W'(1);
                    if (32'(pos_reg) == KMER_LEN - 1)
                    begin
                        rem_reg <= '0;
                        bit_reg <= 6'd31;
                    end
                end
            ST_MOD:
                begin
                    if (rem_sh >= {1'b0, mod_reg})
                        rem_reg <= (IDX_W+1)'(rem_sh - {1'b0, mod_reg});
                    else
                        rem_reg <= rem_sh[IDX_W:0];
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd0)
                    begin
                        scratch[hidx_reg[HS_W-1:0]] <= (rem_sh >= {1'b0, mod_reg}) ?
                            IDX_W'(rem_sh - {1'b0, mod_reg}) : rem_sh[IDX_W-1:0];
                        acc_reg  <= '0;
                        pw_reg   <= HASH_W'(1);
                        base_reg <= HASH_W'(hidx_reg) + HASH_W'(2);
                        pos_reg  <= '0;
                    end
                end
            ST_OUT: if (!ovalid_reg) onew_reg <= fresh_reg;
            default: ;
        endcase
    end

    // filter memory: one 32-bit row per access
    logic [ROW_W-1:0] row_addr;
    assign row_addr = (IDX_W > 5) ? ROW_W'(cur_idx >> 5) : '0;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_reg] <= '0;
        else if (state_reg == ST_SET && fresh_reg && phase_reg)
            mem[row_addr] <= rdata_reg | (32'(1) << cur_idx[4:0]);
        rdata_reg <= mem[row_addr];
    end

endmodule

>>> src/kbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_checker
// port-level checks of the k-mer bloom filter insert block
// ----------------------------------------------------------------------------
module kbf_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_is_new,
    input logic [31:0] out_count
);
    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_is_new))
        else $error("result word changed under stall");

    // a taken result word is not followed by another in the next cycle
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result word repeated");

    // count moves only with a new k-mer
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !out_is_new |-> $stable(out_count))
        else $error("count moved without new k-mer");

    // an offered input word stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn");
endmodule

bind kmer_bloom_filter_insert kbf_props u_kbf_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_is_new(out_ch.is_new),
    .out_count (out_ch.distinct_count)
);

>>> tb/kbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_checker
// watches the input, output and configuration channels of the k-mer bloom
// filter block, keeps its own window, filter and counter, and compares every
// output word with the oldest predicted one
// ----------------------------------------------------------------------------
module kbf_checker
    import kbf_pkg::*;
#(
    parameter int KMER_LEN   = 40,
    parameter int MAX_HASHES = 8,
    parameter int STORE_BITS = 65536
)(
    input  logic clk,
    input  logic rst_n,
    kbf_in_if    in_ch,
    kbf_out_if   out_ch,
    kbf_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic        is_new;
        logic [31:0] distinct_count;
    } kmer_result_t;

    logic [FBITS_W-1:0] filter_bits;
    logic [HCNT_W-1:0]  hash_count;
    logic [CHAR_W-1:0]  window [KMER_LEN];
    int                 fill;
    bit                 filter_mem [STORE_BITS];
    logic [CNT_W-1:0]   new_total;
    kmer_result_t       expected_q [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [HASH_W-1:0] poly_hash(input logic [HASH_W-1:0] base);
        logic [HASH_W-1:0] acc;
        logic [HASH_W-1:0] pw;
        acc = '0;
        pw  = 1;
        for (int j = 0; j < KMER_LEN; j++)
        begin
            pw  = pw * base;
            acc = acc + HASH_W'(window[j]) * pw;
        end
        return acc;
    endfunction

    task automatic take_char(input logic [7:0] ch, input logic start);
        int unsigned modulus;
        int unsigned nh;
        int unsigned idx [MAX_HASHES];
        bit          fresh;
        kmer_result_t r;
        if (start)
        begin
            foreach (window[j]) window[j] = '0;
            fill = 0;
        end
        for (int j = 0; j < KMER_LEN - 1; j++) window[j] = window[j+1];
        window[KMER_LEN-1] = ch;
        if (fill < KMER_LEN) fill++;
        if (fill < KMER_LEN) return;
        modulus = filter_bits;
        if (modulus == 0) modulus = 1;
        if (modulus > STORE_BITS) modulus = STORE_BITS;
        nh = hash_count;
        if (nh == 0) nh = 1;
        if (nh > MAX_HASHES) nh = MAX_HASHES;
        fresh = 0;
        for (int i = 0; i < nh; i++)
        begin
            idx[i] = poly_hash(i + 1) % modulus;
            if (!filter_mem[idx[i]]) fresh = 1;
        end
        if (fresh)
        begin
            for (int i = 0; i < nh; i++) filter_mem[idx[i]] = 1;
            if (new_total != '1) new_total++;
        end
        r.is_new         = fresh;
        r.distinct_count = new_total;
        expected_q = {expected_q, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kmer_result_t w;
        if (!rst_n)
        begin
            filter_bits = FILTER_BITS_RST;
            hash_count  = HASH_COUNT_RST;
            foreach (window[j]) window[j] = '0;
            foreach (filter_mem[k]) filter_mem[k] = 0;
            fill       = 0;
            new_total  = '0;
            fail_count = 0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FILTER_BITS) filter_bits = cfg.data[FBITS_W-1:0];
                else if (cfg.index == REG_HASH_COUNT) hash_count = cfg.data[HCNT_W-1:0];
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected word", out_ch.distinct_count, 0);
                else
                begin
                    w = expected_q.pop_front();
                    if (out_ch.is_new !== w.is_new)
                        report("is_new", out_ch.is_new, w.is_new);
                    if (out_ch.distinct_count !== w.distinct_count)
                        report("distinct_count", out_ch.distinct_count, w.distinct_count);
                end
            end
            if (in_ch.valid && in_ch.ready)
                take_char(in_ch.base_char, in_ch.read_start);
            pending = expected_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives characters in bursts and reads with random stalls; reads are mostly
// short, so k-mers complete often, with some repeated reads to hit set bits
// ----------------------------------------------------------------------------
module tb_top
    import kbf_pkg::*;
();

    localparam int KLEN = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    bit   long_hold;
    bit   hold_done;

    kbf_in_if  in_ch ();
    kbf_out_if out_ch ();
    kbf_cfg_if cfg ();

    kmer_bloom_filter_insert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    kbf_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // receiver: random stall pattern, plus one long hold
    initial
    begin
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_done)
            begin
                out_ch.ready = 0;
                repeat (3000) @(negedge clk);
                hold_done = 1;
            end
            else if (($urandom >> 4) % 64 < 32)
                out_ch.ready = 1;
            else if (($urandom >> 4) % 64 < 48)
                out_ch.ready = $urandom_range(0, 1);
            else
                out_ch.ready = 0;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic start);
        in_ch.valid      <= 1;
        in_ch.base_char  <= ch;
        in_ch.read_start <= start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic idle_in(input int n);
        in_ch.valid <= 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (800) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    // one read of given length; kind 1 takes its content from the seed
    task automatic send_read(input int len, input int kind, input logic [7:0] seed);
        logic [7:0] ch;
        int         burst;
        burst = $urandom_range(1, 30);
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                0: ch = 8'($urandom);
                1: ch = seed + 8'(k);
                2: ch = 8'hff;
                default: ch = 8'($urandom_range(0, 3) * 8'h11 + 8'h41);
            endcase
            send_char(ch, k == 0 ? 1'b1 : ($urandom_range(0, 99) == 0));
            burst--;
            if (burst == 0)
            begin
                idle_in($urandom_range(1, 12));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.base_char = 0;
        in_ch.read_start = 0;
        cfg.valid = 0;
        cfg.index = REG_FILTER_BITS;
        cfg.data = 0;
        sent = 0;
        long_hold = 0;
        hold_done = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;

        // directed: reset config, all-ones and zero windows, a repeat
        send_read(KLEN + 2, 2, 0);
        send_char(8'h00, 1);
        for (int k = 1; k < KLEN; k++) send_char(8'h00, 0);
        send_read(KLEN, 2, 0);
        drain();

        // extreme settings: smallest and over-range filter sizes, 0 and over-range hash counts
        write_reg(REG_FILTER_BITS, 0);
        write_reg(REG_HASH_COUNT, 0);
        send_read(KLEN + 1, 0, 0);
        drain();
        write_reg(REG_FILTER_BITS, 32'h1ffff);
        write_reg(REG_HASH_COUNT, 15);
        send_read(KLEN + 1, 1, 8'h80);
        drain();
        write_reg(REG_FILTER_BITS, 1);
        write_reg(REG_HASH_COUNT, 8);
        send_read(KLEN + 2, 3, 0);
        drain();

        // long receiver hold while input keeps coming
        write_reg(REG_FILTER_BITS, 65536);
        write_reg(REG_HASH_COUNT, 1);
        long_hold = 1;
        send_read(KLEN + 4, 0, 0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_reg(REG_FILTER_BITS, 47925);
                1: write_reg(REG_FILTER_BITS, $urandom_range(1, 64));
                2: write_reg(REG_FILTER_BITS, 65536);
                default: write_reg(REG_FILTER_BITS, $urandom_range(1000, 70000));
            endcase
            write_reg(REG_HASH_COUNT, $urandom_range(1, 8));
            repeat (3)
                send_read(KLEN + $urandom_range(0, 20), $urandom_range(0, 3), 8'($urandom));
            drain();
        end
        in_ch.valid <= 0;
        drain();
        if (fail_count == 0)
            $display("kmer_bloom_filter_insert test passed");
        else
            $display("kmer_bloom_filter_insert test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("kmer_bloom_filter_insert test failed");
        $finish;
    end

endmodule

>>> filelist.f
src/kbf_pkg.sv
src/kbf_if.sv
src/kmer_bloom_filter_insert.sv
src/kbf_checker.sv
tb/kbf_checker.sv
tb/tb_top.sv
